// ===== rtl/sxp_pkg.sv =====
package sxp_pkg;

    localparam int DEPTH_MAX_DEF = 255;
    localparam logic [7:0] DEPTH_LIMIT_RST = 8'd255;
    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
    localparam int EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);
    localparam int EV_PER_BYTE = 3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    localparam logic [7:0] ERR_STRAY_CLOSE  = 8'd0;
    localparam logic [7:0] ERR_NO_SEP       = 8'd1;
    localparam logic [7:0] ERR_OPEN_QUOTE   = 8'd2;
    localparam logic [7:0] ERR_UNCLOSED     = 8'd3;
    localparam logic [7:0] ERR_TOO_DEEP     = 8'd4;
    localparam logic [7:0] ERR_NUL          = 8'd5;
    localparam logic [7:0] ERR_NO_EXPR      = 8'd6;

    typedef enum logic [2:0] {
        M_START   = 3'd0,
        M_UNQ     = 3'd1,
        M_QUO     = 3'd2,
        M_QSEEN   = 3'd3,
        M_COMMENT = 3'd4,
        M_ERR     = 3'd5
    } sxp_mode_t;

    typedef enum logic [2:0] {
        K_OPEN  = 3'd0,
        K_CLOSE = 3'd1,
        K_BYTE  = 3'd2,
        K_END   = 3'd3,
        K_ERR   = 3'd4
    } sxp_kind_t;

    typedef struct packed {
        sxp_mode_t  mode;
        logic [7:0] depth;
        logic       need_sep;
        logic       seen;
    } sxp_state_t;

    typedef struct packed {
        sxp_kind_t  kind;
        logic [7:0] data;
        logic [7:0] depth;
        logic       done;
        logic       last;
    } sxp_ev_t;

    typedef sxp_ev_t [EV_PER_BYTE-1:0] sxp_ev_set_t;

endpackage

// ===== rtl/s_expression_stream_parser_core.sv =====
// Streaming S-expression parser: one text byte per beat in, flat parse events out
// (open, close, atom byte, atom end, error), each with the list depth after it.
// A byte is taken every cycle while the output side keeps up; one byte causes up
// to three events, which leave one per cycle while m_tready is high through a
// four-entry event queue. s_tready is high while it holds at most one event, so a
// byte that makes several events holds off the next byte while the queue drains.
// After an error, bytes are swallowed without events until the beat marked tlast,
// which clears the parse state without end-of-buffer checks. cfg_we/cfg_wdata
// write the depth limit (reset 255); write it only while the block is idle.
module s_expression_stream_parser_core
    import sxp_pkg::*;
#(
    parameter int MAX_DEPTH = DEPTH_MAX_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data, [15:8] depth, [16] expr_done, rest zero
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    sxp_state_t           state_reg;
    sxp_state_t           state_next;
    logic [7:0]           depth_limit_reg;
    sxp_ev_set_t          step_evs;
    logic [1:0]           step_cnt;
    logic [1:0]           push_n;
    logic [EVQ_CNT_W-1:0] q_count;
    sxp_ev_t              out_ev;
    logic                 accept;

    assign s_tready = (q_count <= EVQ_CNT_W'(EVQ_DEPTH - EV_PER_BYTE));
    assign accept = s_tvalid && s_tready;
    assign push_n = accept ? step_cnt : 2'd0;

    sxp_step #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_step (
        .cur         (state_reg),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .depth_limit (depth_limit_reg),
        .nxt         (state_next),
        .evs         (step_evs),
        .ev_cnt      (step_cnt)
    );

    sxp_evq u_evq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_ev   (step_evs),
        .count     (q_count),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_ev    (out_ev)
    );

    assign m_tdata = {7'd0, out_ev.done, out_ev.depth, out_ev.data};
    assign m_tuser = out_ev.kind;
    assign m_tlast = out_ev.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{M_START, 8'd0, 1'b0, 1'b0};
            depth_limit_reg <= DEPTH_LIMIT_RST;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (cfg_we)
            begin
                depth_limit_reg <= cfg_wdata;
            end
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s_tlast |=> (state_reg.mode == M_START) && (state_reg.depth == 8'd0)
            && !state_reg.seen)
        else $error("parse state not cleared after the last beat");

    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (state_reg.mode == M_ERR) && !s_tlast |-> (step_cnt == 2'd0))
        else $error("events produced while swallowing after an error");

    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !s_tlast |=> (state_reg.depth == $past(state_reg.depth))
            || (state_reg.depth == $past(state_reg.depth) + 8'd1)
            || (state_reg.depth == $past(state_reg.depth) - 8'd1))
        else $error("nesting depth moved by more than one on a beat");

endmodule

// ===== rtl/sxp_step.sv =====
module sxp_step
    import sxp_pkg::*;
#(
    parameter int MAX_DEPTH = DEPTH_MAX_DEF
)
(
    input  sxp_state_t  cur,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic [7:0]  depth_limit,
    output sxp_state_t  nxt,
    output sxp_ev_set_t evs,
    output logic [1:0]  ev_cnt
);

    localparam logic [15:0] MaxDepth = 16'(MAX_DEPTH);

    logic [15:0] lim;

    assign lim = ({8'd0, depth_limit} > MaxDepth) ? MaxDepth : {8'd0, depth_limit};

    always_comb
    begin
        sxp_state_t  st;
        sxp_ev_set_t ev;
        logic [1:0]  n;
        logic        end_first;
        logic        run_start;
        logic        top;
        logic [7:0]  b;

        st = cur;
        ev = '0;
        n = 2'd0;
        end_first = 1'b0;
        run_start = 1'b0;
        top = 1'b0;
        b = in_byte;

        case (cur.mode)
            M_ERR:
            begin
            end
            M_UNQ:
            begin
                if (b == CH_NUL)
                begin
                    ev[n] = sxp_ev_t'{K_ERR, ERR_NUL, st.depth, 1'b0, 1'b0};
                    n = n + 2'd1;
                    st.mode = M_ERR;
                end
                else if (b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_LPAREN, CH_RPAREN})
                begin
                    end_first = 1'b1;
                    run_start = 1'b1;
                end
                else
                begin
                    ev[n] = sxp_ev_t'{K_BYTE, b, st.depth, 1'b0, 1'b0};
                    n = n + 2'd1;
                end
            end
            M_QUO:
            begin
                if (b == CH_NUL)
                begin
                    ev[n] = sxp_ev_t'{K_ERR, ERR_NUL, st.depth, 1'b0, 1'b0};
                    n = n + 2'd1;
                    st.mode = M_ERR;
                end
                else if (b == CH_QUOTE)
                begin
                    st.mode = M_QSEEN;
                end
                else
                begin
                    ev[n] = sxp_ev_t'{K_BYTE, b, st.depth, 1'b0, 1'b0};
                    n = n + 2'd1;
                end
            end
            M_QSEEN:
            begin
                // A second quote is an escaped quote byte; anything else closes the atom.
                if (b == CH_QUOTE)
                begin
                    ev[n] = sxp_ev_t'{K_BYTE, b, st.depth, 1'b0, 1'b0};
                    n = n + 2'd1;
                    st.mode = M_QUO;
                end
                else
                begin
                    end_first = 1'b1;
                    run_start = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (b == CH_NUL)
                begin
                    ev[n] = sxp_ev_t'{K_ERR, ERR_NUL, st.depth, 1'b0, 1'b0};
                    n = n + 2'd1;
                    st.mode = M_ERR;
                end
                else if (b == CH_LF)
                begin
                    st.mode = M_START;
                end
            end
            default:
            begin
                st.mode = M_START;
                run_start = 1'b1;
            end
        endcase

        if (end_first)
        begin
            top = (st.depth == 8'd0);
            ev[n] = sxp_ev_t'{K_END, 8'd0, st.depth, top, 1'b0};
            n = n + 2'd1;
            st.need_sep = !top;
            st.seen = st.seen | top;
            st.mode = M_START;
        end

        if (run_start)
        begin
            if (b == CH_NUL)
            begin
                ev[n] = sxp_ev_t'{K_ERR, ERR_NUL, st.depth, 1'b0, 1'b0};
                n = n + 2'd1;
                st.mode = M_ERR;
            end
            else if (b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})
            begin
                st.need_sep = 1'b0;
                st.mode = M_START;
            end
            else if (b == CH_SEMI)
            begin
                st.need_sep = 1'b0;
                st.mode = M_COMMENT;
            end
            else if (b == CH_RPAREN)
            begin
                if (st.depth == 8'd0)
                begin
                    ev[n] = sxp_ev_t'{K_ERR, ERR_STRAY_CLOSE, st.depth, 1'b0, 1'b0};
                    n = n + 2'd1;
                    st.mode = M_ERR;
                end
                else
                begin
                    st.depth = st.depth - 8'd1;
                    top = (st.depth == 8'd0);
                    ev[n] = sxp_ev_t'{K_CLOSE, 8'd0, st.depth, top, 1'b0};
                    n = n + 2'd1;
                    st.need_sep = !top;
                    st.seen = st.seen | top;
                    st.mode = M_START;
                end
            end
            else if (st.need_sep && (st.depth != 8'd0))
            begin
                ev[n] = sxp_ev_t'{K_ERR, ERR_NO_SEP, st.depth, 1'b0, 1'b0};
                n = n + 2'd1;
                st.mode = M_ERR;
            end
            else if (b == CH_LPAREN)
            begin
                if ({8'd0, st.depth} >= lim)
                begin
                    ev[n] = sxp_ev_t'{K_ERR, ERR_TOO_DEEP, st.depth, 1'b0, 1'b0};
                    n = n + 2'd1;
                    st.mode = M_ERR;
                end
                else
                begin
                    st.depth = st.depth + 8'd1;
                    ev[n] = sxp_ev_t'{K_OPEN, 8'd0, st.depth, 1'b0, 1'b0};
                    n = n + 2'd1;
                    st.need_sep = 1'b0;
                    st.mode = M_START;
                end
            end
            else if (b == CH_QUOTE)
            begin
                st.mode = M_QUO;
            end
            else
            begin
                ev[n] = sxp_ev_t'{K_BYTE, b, st.depth, 1'b0, 1'b0};
                n = n + 2'd1;
                st.mode = M_UNQ;
            end
        end

        // End of buffer: close a pending atom, then report at most one end error.
        // Only this path can ask for a fourth event, which is dropped.
        if (in_last)
        begin
            if (st.mode != M_ERR)
            begin
                if ((st.mode == M_UNQ) || (st.mode == M_QSEEN))
                begin
                    top = (st.depth == 8'd0);
                    ev[n] = sxp_ev_t'{K_END, 8'd0, st.depth, top, 1'b0};
                    n = n + 2'd1;
                    st.need_sep = !top;
                    st.seen = st.seen | top;
                    st.mode = M_START;
                end
                if (st.mode == M_QUO)
                begin
                    if (n != 2'd3)
                    begin
                        ev[n] = sxp_ev_t'{K_ERR, ERR_OPEN_QUOTE, st.depth, 1'b0, 1'b0};
                        n = n + 2'd1;
                    end
                end
                else if (st.depth != 8'd0)
                begin
                    if (n != 2'd3)
                    begin
                        ev[n] = sxp_ev_t'{K_ERR, ERR_UNCLOSED, st.depth, 1'b0, 1'b0};
                        n = n + 2'd1;
                    end
                end
                else if (!st.seen)
                begin
                    if (n != 2'd3)
                    begin
                        ev[n] = sxp_ev_t'{K_ERR, ERR_NO_EXPR, st.depth, 1'b0, 1'b0};
                        n = n + 2'd1;
                    end
                end
            end
            st.mode = M_START;
            st.depth = 8'd0;
            st.need_sep = 1'b0;
            st.seen = 1'b0;
        end

        if (n != 2'd0)
        begin
            ev[n - 2'd1].last = 1'b1;
        end

        nxt = st;
        evs = ev;
        ev_cnt = n;
    end

endmodule

// ===== rtl/sxp_evq.sv =====
module sxp_evq
    import sxp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           push_n,
    input  sxp_ev_set_t          push_ev,
    output logic [EVQ_CNT_W-1:0] count,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sxp_ev_t              out_ev
);

    sxp_ev_t                mem [EVQ_DEPTH];
    logic [EVQ_PTR_W-1:0]   wr_ptr_reg;
    logic [EVQ_PTR_W-1:0]   wr_ptr_next;
    logic [EVQ_PTR_W-1:0]   rd_ptr_reg;
    logic [EVQ_PTR_W-1:0]   rd_ptr_next;
    logic [EVQ_CNT_W-1:0]   count_reg;
    logic [EVQ_CNT_W-1:0]   count_next;
    logic                   pop;

    assign pop = out_ready && (count_reg != '0);
    assign out_valid = (count_reg != '0);
    assign out_ev = mem[rd_ptr_reg];
    assign count = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + EVQ_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + EVQ_PTR_W'(pop);
        count_next = count_reg + EVQ_CNT_W'(push_n) - EVQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < EV_PER_BYTE; i++)
        begin
            if (i < int'(push_n))
            begin
                mem[wr_ptr_reg + EVQ_PTR_W'(i)] <= push_ev[i];
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |-> (count_reg + EVQ_CNT_W'(push_n) <= EVQ_CNT_W'(EVQ_DEPTH)))
        else $error("event queue overflow");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd0) && pop |=> (count_reg == $past(count_reg) - EVQ_CNT_W'(1)))
        else $error("event queue count did not drop on a pop");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg < EVQ_CNT_W'(EVQ_DEPTH)) |->
            ((wr_ptr_reg - rd_ptr_reg) == EVQ_PTR_W'(count_reg)))
        else $error("event queue pointers disagree with count");

endmodule
